// ===== hdl/mse_pkg.sv =====
// Shared constants, types and log table for the Mandelbrot smooth escape-time block.
package mse_pkg;

   localparam int FRAC_BITS = 28;
   localparam int CNT_W = 16;
   localparam int TAB_DEPTH = 256;
   localparam int TAB_BITS = $clog2(TAB_DEPTH);
   localparam logic [127:0] ESC_THRESH = 128'(64'd10000000000) << (2 * FRAC_BITS);
   localparam logic [31:0] LOG_SCALE = 32'd129291399;

   typedef logic [15:0] log_tab_type [TAB_DEPTH];

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOP,
      ST_RI,
      ST_UPDATE,
      ST_SQ_RE,
      ST_SQ_IM,
      ST_SUM,
      ST_CMP,
      ST_NORM,
      ST_SCALE,
      ST_DONE
   } state_type;

   function automatic log_tab_type build_log_tab();
      log_tab_type tab;
      logic [63:0] x;
      logic [23:0] y;
      for (int k = 0; k < TAB_DEPTH; k++) begin
         x = (64'd1 << 30) + (64'(k) << (30 - TAB_BITS));
         y = '0;
         for (int i = 1; i <= 24; i++) begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31)) begin
               x = x >> 1;
               y[24 - i] = 1'b1;
            end
         end
         tab[k] = 16'((25'(y) + 25'd128) >> 8);
      end
      return tab;
   endfunction

   localparam log_tab_type LOG_TAB = build_log_tab();

endpackage

// ===== hdl/mse_mul32.sv =====
// Shared 32x32 unsigned multiplier with registered product.
module mse_mul32 (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] prod_ff
);
   logic [63:0] prod_in;

   assign prod_in = 64'(mul_a) * 64'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

// ===== hdl/mandelbrot_smooth_escape_time.sv =====
// Each iteration forms three 64-bit products from four 32x32 partials each on one multiplier,
// plus limit check, update, sum and compare; a point that reaches the limit goes to the result,
// while an escaped point first runs a leading-one search and scaling before the result is
// registered. Throughput: one point at a time; the next transfer is taken once the result is
// registered. Reset: synchronous, active high; clears the sequencer and result valid and sets
// max_iterations to 256.
module mandelbrot_smooth_escape_time (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // c_real [31:0], c_imag [63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // iterations [15:0], smooth_count [47:16]
   output logic        rsp_tuser,   // escaped [0]
   input  logic        csr_we,
   input  logic [15:0] csr_wdata    // max_iterations
);
   import mse_pkg::*;

   state_type state_ff, state_in;
   logic [2:0]   step_ff, step_in;
   logic [1:0]   sh_ff, sh_in;
   logic [127:0] acc_ff, acc_in, prr_ff, prr_in, pii_ff, pii_in, a2_ff, a2_in;
   logic [63:0]  re_ff, re_in, im_ff, im_in;
   logic [31:0]  cr_ff, cr_in, ci_ff, ci_in;
   logic [CNT_W-1:0] count_ff, count_in, limit_ff, limit_in;
   logic [6:0]   msb_ff, msb_in;
   logic [31:0]  lval_ff, lval_in;
   logic         esc_ff, esc_in;
   logic [31:0]  smooth_ff, smooth_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] rsp_iter_ff, rsp_iter_in;
   logic         rsp_esc_ff, rsp_esc_in;
   logic [31:0]  rsp_smooth_ff, rsp_smooth_in;

   logic [63:0]  mag_re, mag_im, opa, opb, pp;
   logic [31:0]  mul_a, mul_b;
   logic [1:0]   part;
   logic [127:0] pp_ext, shifted, acc_sum;
   logic [127:0] ri2;
   logic [63:0]  q_im, new_im_mag, new_re, new_im;
   logic         neg_im;
   logic [6:0]   exp_part;
   logic [31:0]  term;
   logic signed [34:0] s_val;

   mse_mul32 u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (pp)
   );

   assign mag_re = re_ff[63] ? (64'd0 - re_ff) : re_ff;
   assign mag_im = im_ff[63] ? (64'd0 - im_ff) : im_ff;

   always_comb begin
      unique case (state_ff)
         ST_RI: begin
            opa = mag_re;
            opb = mag_im;
         end
         ST_SQ_RE: begin
            opa = mag_re;
            opb = mag_re;
         end
         ST_SQ_IM: begin
            opa = mag_im;
            opb = mag_im;
         end
         default: begin
            opa = 64'(lval_ff);
            opb = 64'(LOG_SCALE);
         end
      endcase
   end

   assign part  = step_ff[1:0];
   assign mul_a = part[0] ? opa[63:32] : opa[31:0];
   assign mul_b = part[1] ? opb[63:32] : opb[31:0];
   assign sh_in = 2'(part[0]) + 2'(part[1]);

   assign pp_ext = 128'(pp);
   always_comb begin
      unique case (sh_ff)
         2'd0:    shifted = pp_ext;
         2'd1:    shifted = pp_ext << 32;
         2'd2:    shifted = pp_ext << 64;
         default: shifted = pp_ext << 96;
      endcase
   end
   assign acc_sum = acc_ff + shifted;

   assign new_re = prr_ff[FRAC_BITS +: 64] - pii_ff[FRAC_BITS +: 64] + 64'(signed'(cr_ff));
   assign ri2 = acc_ff << 1;
   assign q_im = ri2[FRAC_BITS +: 64];
   assign new_im_mag = q_im + 64'(ri2[FRAC_BITS-1:0] != '0);
   assign neg_im = re_ff[63] ^ im_ff[63];
   assign new_im = (neg_im ? (64'd0 - new_im_mag) : q_im) + 64'(signed'(ci_ff));

   assign exp_part = msb_ff - 7'(2 * FRAC_BITS);
   assign term = 32'((pp + 64'h8000_0000) >> 32);
   assign s_val = $signed({1'b0, 18'(count_ff) + 18'd2, 16'd0}) - $signed({3'd0, term});

   assign limit_in = csr_we ? csr_wdata : limit_ff;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      acc_in = acc_ff;
      prr_in = prr_ff;
      pii_in = pii_ff;
      a2_in = a2_ff;
      re_in = re_ff;
      im_in = im_ff;
      cr_in = cr_ff;
      ci_in = ci_ff;
      count_in = count_ff;
      msb_in = msb_ff;
      lval_in = lval_ff;
      esc_in = esc_ff;
      smooth_in = smooth_ff;
      rsp_iter_in = rsp_iter_ff;
      rsp_esc_in = rsp_esc_ff;
      rsp_smooth_in = rsp_smooth_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cr_in = req_tdata[31:0];
               ci_in = req_tdata[63:32];
               re_in = '0;
               im_in = '0;
               prr_in = '0;
               pii_in = '0;
               count_in = '0;
               esc_in = 1'b0;
               smooth_in = '0;
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            step_in = '0;
            if (count_ff < limit_ff) begin
               state_in = ST_RI;
            end else begin
               esc_in = 1'b0;
               smooth_in = '0;
               state_in = ST_DONE;
            end
         end
         ST_RI, ST_SQ_RE, ST_SQ_IM: begin
            acc_in = (step_ff == 3'd0) ? '0 : acc_sum;
            step_in = step_ff + 3'd1;
            if (state_ff == ST_SQ_IM && step_ff == 3'd0) begin
               prr_in = acc_ff;
            end
            if (step_ff == 3'd4) begin
               step_in = '0;
               priority case (state_ff)
                  ST_RI:    state_in = ST_UPDATE;
                  ST_SQ_RE: state_in = ST_SQ_IM;
                  default:  state_in = ST_SUM;
               endcase
            end
         end
         ST_UPDATE: begin
            re_in = new_re;
            im_in = new_im;
            count_in = count_ff + CNT_W'(1);
            step_in = '0;
            state_in = ST_SQ_RE;
         end
         ST_SUM: begin
            pii_in = acc_ff;
            a2_in = prr_ff + acc_ff;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (a2_ff > ESC_THRESH) begin
               esc_in = 1'b1;
               msb_in = 7'd127;
               state_in = ST_NORM;
            end else begin
               state_in = ST_LOOP;
            end
         end
         ST_NORM: begin
            if (a2_ff[127]) begin
               lval_in = {9'd0, exp_part, 16'd0} + {16'd0, LOG_TAB[a2_ff[126 -: TAB_BITS]]};
               step_in = '0;
               state_in = ST_SCALE;
            end else begin
               a2_in = a2_ff << 1;
               msb_in = msb_ff - 7'd1;
            end
         end
         ST_SCALE: begin
            if (step_ff == 3'd0) begin
               step_in = 3'd1;
            end else begin
               step_in = '0;
               priority if (s_val < 0) begin
                  smooth_in = '0;
               end else if (s_val[33:32] != 2'd0) begin
                  smooth_in = '1;
               end else begin
                  smooth_in = s_val[31:0];
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_iter_in = count_ff;
               rsp_esc_in = esc_ff;
               rsp_smooth_in = smooth_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         limit_ff <= 16'd256;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         limit_ff <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff <= sh_in;
      acc_ff <= acc_in;
      prr_ff <= prr_in;
      pii_ff <= pii_in;
      a2_ff <= a2_in;
      re_ff <= re_in;
      im_ff <= im_in;
      cr_ff <= cr_in;
      ci_ff <= ci_in;
      count_ff <= count_in;
      msb_ff <= msb_in;
      lval_ff <= lval_in;
      esc_ff <= esc_in;
      smooth_ff <= smooth_in;
      rsp_iter_ff <= rsp_iter_in;
      rsp_esc_ff <= rsp_esc_in;
      rsp_smooth_ff <= rsp_smooth_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_smooth_ff, rsp_iter_ff};
   assign rsp_tuser = rsp_esc_ff;
endmodule
